// ===== rtl/font_cmap_glyph_lookup_unit_macros.svh =====
// ----------------------------------------------------------------------------
// font_cmap_glyph_lookup_unit_macros.svh
// Assertion macros used by the glyph lookup sequencer (fcmap_seq).
// ----------------------------------------------------------------------------
`ifndef FONT_CMAP_GLYPH_LOOKUP_UNIT_MACROS_SVH
`define FONT_CMAP_GLYPH_LOOKUP_UNIT_MACROS_SVH

// same-cycle implication
`define FCMAP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fcmap assertion failed");

// next-cycle implication
`define FCMAP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fcmap assertion failed");

`endif

// ===== rtl/fcmap_pkg.sv =====
// ----------------------------------------------------------------------------
// fcmap_pkg
// Constants and types of the character-map glyph lookup.
// ----------------------------------------------------------------------------
`default_nettype none
package fcmap_pkg;
  localparam int TABLE_WORDS  = 8192;
  localparam int ADDR_W       = $clog2(TABLE_WORDS);
  localparam int MAX_SEGMENTS = 2048;
  localparam int SEG_W        = 12;
  localparam int GADDR_W      = 18;

  localparam logic [2:0] FMT_BYTE      = 3'd0;
  localparam logic [2:0] FMT_HIGH_BYTE = 3'd2;
  localparam logic [2:0] FMT_SEGMENT   = 3'd4;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_SEGCNT = 1'b1;

  localparam int F0_BASE       = 3;
  localparam int F2_KEY_BASE   = 3;
  localparam int F2_SUB_BASE   = 259;
  localparam int F4_END_BASE   = 7;
  localparam int F4_START_BASE = 8;

  typedef struct packed {
    logic [2:0]       table_format;
    logic [SEG_W-1:0] segment_count;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [15:0]       wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;
endpackage
`default_nettype wire

// ===== rtl/fcmap_if.sv =====
// ----------------------------------------------------------------------------
// fcmap_if
// Request and response channels of the glyph lookup.
// ----------------------------------------------------------------------------
`default_nettype none
interface fcmap_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [12:0] word_address;
  logic [15:0] word_data;
  logic [20:0] char_code;
  modport source (output valid, func, word_address, word_data, char_code, input ready);
  modport sink (input valid, func, word_address, word_data, char_code, output ready);
endinterface

interface fcmap_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] glyph_id;
  logic        table_fault;
  modport source (output valid, glyph_id, table_fault, input ready);
  modport sink (input valid, glyph_id, table_fault, output ready);
endinterface
`default_nettype wire

// ===== rtl/fcmap_ram.sv =====
// ----------------------------------------------------------------------------
// fcmap_ram
// Table word store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module fcmap_ram
  import fcmap_pkg::*;
(
  input  wire logic     clk,
  input  wire ram_req_t ram_req,
  output logic [15:0]   rdata
);
  logic [15:0] mem [TABLE_WORDS];

  always_ff @(posedge clk) begin
    if (ram_req.we) begin
      mem[ram_req.waddr] <= ram_req.wdata;
    end
    rdata <= mem[ram_req.raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/fcmap_seq.sv =====
// ----------------------------------------------------------------------------
// fcmap_seq
// Lookup sequencer: walks the subtable through the single RAM read port.
// ----------------------------------------------------------------------------
`default_nettype none
`include "font_cmap_glyph_lookup_unit_macros.svh"
module fcmap_seq
  import fcmap_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  fcmap_req_if.sink        req,
  fcmap_rsp_if.source      rsp,
  output ram_req_t         ram_req,
  input  wire logic [15:0] ram_rdata
);
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_F0_DATA  = 4'd1;
  localparam logic [3:0] S_F2_KEY   = 4'd2;
  localparam logic [3:0] S_F2_FIRST = 4'd3;
  localparam logic [3:0] S_F2_CNT   = 4'd4;
  localparam logic [3:0] S_F2_DELTA = 4'd5;
  localparam logic [3:0] S_F2_RO    = 4'd6;
  localparam logic [3:0] S_ADDR     = 4'd7;
  localparam logic [3:0] S_GLYPH    = 4'd8;
  localparam logic [3:0] S_F4_END   = 4'd9;
  localparam logic [3:0] S_F4_START = 4'd10;
  localparam logic [3:0] S_F4_DELTA = 4'd11;
  localparam logic [3:0] S_F4_RO    = 4'd12;
  localparam logic [3:0] S_FIN      = 4'd13;

  logic [3:0]       state;
  logic [15:0]      code;
  logic [SEG_W-1:0] nseg;
  logic [SEG_W-1:0] seg;
  logic [16:0]      sh;
  logic [15:0]      first;
  logic [15:0]      count;
  logic [15:0]      delta;
  logic [15:0]      ro;
  logic [15:0]      start;
  logic [16:0]      base;
  logic [15:0]      offs;
  logic [13:0]      roaddr;
  logic [15:0]      glyph;
  logic             fault;
  logic             out_valid;
  logic [15:0]      out_glyph;
  logic             out_fault;

  logic             acc;
  logic [SEG_W-1:0] nsat;
  logic [16:0]      sh_new;
  logic [17:0]      sh_top;
  logic [15:0]      idx;
  logic [SEG_W-1:0] seg_inc;
  logic             found;
  logic [13:0]      start_addr;
  logic [13:0]      delta_addr;
  logic [13:0]      roaddr_new;
  logic [17:0]      gaddr;
  logic             out_free;

  assign acc        = req.valid && req.ready;
  assign req.ready  = (state == S_IDLE);
  assign rsp.valid  = out_valid;
  assign rsp.glyph_id    = out_glyph;
  assign rsp.table_fault = out_fault;
  assign out_free   = !out_valid || rsp.ready;

  assign nsat       = (cfg.segment_count > SEG_W'(MAX_SEGMENTS)) ?
                      SEG_W'(MAX_SEGMENTS) : cfg.segment_count;
  assign sh_new     = 17'(F2_SUB_BASE) + {2'b0, ram_rdata[15:1]};
  assign sh_top     = {1'b0, sh_new} + 18'd3;
  assign idx        = {8'd0, code[7:0]} - first;
  assign seg_inc    = seg + SEG_W'(1);
  assign found      = (ram_rdata >= code);
  assign start_addr = 14'(F4_START_BASE) + {2'b0, nseg} + {2'b0, seg};
  assign delta_addr = start_addr + {2'b0, nseg};
  assign roaddr_new = delta_addr + {2'b0, nseg};
  assign gaddr      = {1'b0, base} + {3'b0, ro[15:1]} + {2'b0, offs};

  always_comb begin
    ram_req.we    = acc && (req.func == FUNC_WRITE);
    ram_req.waddr = req.word_address;
    ram_req.wdata = req.word_data;
    ram_req.raddr = '0;
    case (state)
      S_IDLE: begin
        case (cfg.table_format)
          FMT_BYTE:      ram_req.raddr = ADDR_W'(F0_BASE) + ADDR_W'(req.char_code[7:1]);
          FMT_HIGH_BYTE: ram_req.raddr = ADDR_W'(F2_KEY_BASE) + ADDR_W'(req.char_code[15:8]);
          default:       ram_req.raddr = ADDR_W'(F4_END_BASE);
        endcase
      end
      S_F2_KEY:   ram_req.raddr = sh_new[ADDR_W-1:0];
      S_F2_FIRST: ram_req.raddr = ADDR_W'(sh + 17'd1);
      S_F2_CNT:   ram_req.raddr = ADDR_W'(sh + 17'd2);
      S_F2_DELTA: ram_req.raddr = ADDR_W'(sh + 17'd3);
      S_F4_END: begin
        if (found) begin
          ram_req.raddr = start_addr[ADDR_W-1:0];
        end else begin
          ram_req.raddr = ADDR_W'(F4_END_BASE) + ADDR_W'(seg_inc);
        end
      end
      S_F4_START: ram_req.raddr = delta_addr[ADDR_W-1:0];
      S_F4_DELTA: ram_req.raddr = roaddr_new[ADDR_W-1:0];
      S_ADDR:     ram_req.raddr = gaddr[ADDR_W-1:0];
      default:    ram_req.raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          glyph <= '0;
          fault <= 1'b0;
          code  <= req.char_code[15:0];
          nseg  <= nsat;
          seg   <= '0;
          if (acc && (req.func == FUNC_LOOKUP)) begin
            case (cfg.table_format)
              FMT_BYTE: begin
                state <= (req.char_code[20:8] != '0) ? S_FIN : S_F0_DATA;
              end
              FMT_HIGH_BYTE: begin
                state <= (req.char_code[20:16] != '0) ? S_FIN : S_F2_KEY;
              end
              FMT_SEGMENT: begin
                state <= ((req.char_code[20:16] != '0) || (nsat == '0)) ? S_FIN : S_F4_END;
              end
              default: begin
                fault <= 1'b1;
                state <= S_FIN;
              end
            endcase
          end
        end
        S_F0_DATA: begin
          glyph <= code[0] ? {8'd0, ram_rdata[7:0]} : {8'd0, ram_rdata[15:8]};
          state <= S_FIN;
        end
        S_F2_KEY: begin
          sh <= sh_new;
          if (sh_top >= GADDR_W'(TABLE_WORDS)) begin
            fault <= 1'b1;
            state <= S_FIN;
          end else begin
            state <= S_F2_FIRST;
          end
        end
        S_F2_FIRST: begin
          first <= ram_rdata;
          state <= S_F2_CNT;
        end
        S_F2_CNT: begin
          count <= ram_rdata;
          state <= S_F2_DELTA;
        end
        S_F2_DELTA: begin
          delta <= ram_rdata;
          state <= S_F2_RO;
        end
        S_F2_RO: begin
          ro   <= ram_rdata;
          base <= sh + 17'd3;
          offs <= idx;
          state <= (idx >= count) ? S_FIN : S_ADDR;
        end
        S_ADDR: begin
          if (gaddr >= GADDR_W'(TABLE_WORDS)) begin
            fault <= 1'b1;
            state <= S_FIN;
          end else begin
            state <= S_GLYPH;
          end
        end
        S_GLYPH: begin
          glyph <= (ram_rdata == '0) ? '0 : ram_rdata + delta;
          state <= S_FIN;
        end
        S_F4_END: begin
          if (found) begin
            state <= S_F4_START;
          end else begin
            seg   <= seg_inc;
            state <= (seg_inc == nseg) ? S_FIN : S_F4_END;
          end
        end
        S_F4_START: begin
          start <= ram_rdata;
          state <= (code < ram_rdata) ? S_FIN : S_F4_DELTA;
        end
        S_F4_DELTA: begin
          delta  <= ram_rdata;
          roaddr <= roaddr_new;
          if (roaddr_new >= 14'(TABLE_WORDS)) begin
            fault <= 1'b1;
            state <= S_FIN;
          end else begin
            state <= S_F4_RO;
          end
        end
        S_F4_RO: begin
          ro   <= ram_rdata;
          base <= {3'b0, roaddr};
          offs <= code - start;
          if (ram_rdata == '0) begin
            glyph <= code + delta;
            state <= S_FIN;
          end else begin
            state <= S_ADDR;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_glyph <= fault ? '0 : glyph;
            out_fault <= fault;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FCMAP_ASSERT_IMPL(a_seg_in_range, clk, rst, state == S_F4_END, seg < nseg)
  `FCMAP_ASSERT_IMPL(a_fault_no_glyph, clk, rst, out_valid && out_fault, out_glyph == '0)
  `FCMAP_ASSERT_NEXT(a_lookup_busy, clk, rst, acc && (req.func == FUNC_LOOKUP), state != S_IDLE)
  `FCMAP_ASSERT_NEXT(a_write_stays_idle, clk, rst, acc && (req.func == FUNC_WRITE), state == S_IDLE)
endmodule
`default_nettype wire

// ===== rtl/font_cmap_glyph_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// font_cmap_glyph_lookup_unit
// Character-map glyph lookup, cmap subtable formats 0, 2 and 4.
// ----------------------------------------------------------------------------
// A write word stores one table word and yields no result. A lookup takes
// one word at a time and holds req.ready low until its result is registered.
// Format 4 scans the end codes one per cycle, up to the segment count (capped
// at MAX_SEGMENTS). Every step is paced by the single read port of the table
// RAM, and the result waits while the output register is full. A result may
// wait in the output register while the next word is accepted.
`default_nettype none
module font_cmap_glyph_lookup_unit
  import fcmap_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  fcmap_req_if.sink        req,
  fcmap_rsp_if.source      rsp
);
  cfg_t        cfg;
  ram_req_t    ram_req;
  logic [15:0] ram_rdata;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_SEGCNT) ? {20'd0, cfg.segment_count} :
                  {29'd0, cfg.table_format};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.table_format  <= FMT_SEGMENT;
      cfg.segment_count <= SEG_W'(1);
    end else if (cfg_we) begin
      if (paddr[2] == REG_FORMAT) begin
        cfg.table_format <= pwdata[2:0];
      end else begin
        cfg.segment_count <= pwdata[SEG_W-1:0];
      end
    end
  end

  fcmap_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .rsp       (rsp),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  fcmap_ram u_ram (
    .clk     (clk),
    .ram_req (ram_req),
    .rdata   (ram_rdata)
  );
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cmap glyph lookup unit. The whole table is
// filled first so that every lookup reads defined words. Then directed and
// random phases build format 0, 2 and 4 subtables, some well formed and some
// broken, under several register settings, unsupported formats among them.
// A scoreboard predicts each glyph word and checks the response stream.
// Both channels stall at random.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import fcmap_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;

  class glyph_checker;
    bit [15:0] mem [TABLE_WORDS];
    bit [2:0] fmt = FMT_SEGMENT;
    bit [SEG_W-1:0] segs = 1;
    bit oob;
    logic [16:0] pending_glyphs [$];
    int errors;
    int lookups;

    function int unsigned rd(int unsigned a);
      if (a >= TABLE_WORDS) begin
        oob = 1;
        return 0;
      end
      return mem[a];
    endfunction

    function int unsigned map_f0(int unsigned code);
      int unsigned w;
      if (code >= 256) return 0;
      w = rd(F0_BASE + (code >> 1));
      return code[0] ? (w & 'hFF) : (w >> 8);
    endfunction

    function int unsigned map_f2(int unsigned code);
      int unsigned key, sh, first, cnt, delta, ro, idx, g;
      if (code >= 65536) return 0;
      key = rd(F2_KEY_BASE + (code >> 8));
      if (oob) return 0;
      sh = F2_SUB_BASE + (key >> 1);
      first = rd(sh);
      cnt = rd(sh + 1);
      delta = rd(sh + 2);
      ro = rd(sh + 3);
      if (oob) return 0;
      idx = ((code & 'hFF) - first) & 'hFFFF;
      if (idx >= cnt) return 0;
      g = rd(sh + 3 + (ro >> 1) + idx);
      if (oob || g == 0) return 0;
      return (g + delta) & 'hFFFF;
    endfunction

    function int unsigned map_f4(int unsigned code);
      int unsigned n, s, st, delta, ro, roaddr, g;
      bit hit;
      if (code >= 65536) return 0;
      n = (segs > MAX_SEGMENTS) ? MAX_SEGMENTS : segs;
      hit = 0;
      for (s = 0; s < n; s++) begin
        if (rd(F4_END_BASE + s) >= code) begin
          hit = 1;
          break;
        end
        if (oob) return 0;
      end
      if (oob || !hit) return 0;
      st = rd(F4_START_BASE + n + s);
      if (oob || code < st) return 0;
      delta = rd(F4_START_BASE + 2 * n + s);
      roaddr = F4_START_BASE + 3 * n + s;
      ro = rd(roaddr);
      if (oob) return 0;
      if (ro == 0) return (code + delta) & 'hFFFF;
      g = rd(roaddr + (ro >> 1) + (code - st));
      if (oob || g == 0) return 0;
      return (g + delta) & 'hFFFF;
    endfunction

    function void note_word(bit func, bit [12:0] addr, bit [15:0] data, bit [20:0] code);
      int unsigned g;
      if (func == FUNC_WRITE) begin
        mem[addr] = data;
        return;
      end
      oob = 0;
      case (fmt)
        FMT_BYTE: g = map_f0(code);
        FMT_HIGH_BYTE: g = map_f2(code);
        FMT_SEGMENT: g = map_f4(code);
        default: begin
          g = 0;
          oob = 1;
        end
      endcase
      if (oob) g = 0;
      pending_glyphs.push_back({oob, g[15:0]});
      lookups++;
    endfunction

    function void check_glyph(logic [15:0] glyph, logic fault);
      logic [16:0] exp_word;
      if (pending_glyphs.size() == 0) begin
        $error("unexpected response glyph_id=%0h table_fault=%0b", glyph, fault);
        errors++;
        return;
      end
      exp_word = pending_glyphs.pop_front();
      if (glyph !== exp_word[15:0]) begin
        $error("glyph_id expected %0h actual %0h", exp_word[15:0], glyph);
        errors++;
      end
      if (fault !== exp_word[16]) begin
        $error("table_fault expected %0b actual %0b", exp_word[16], fault);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  bit calm;
  int idle_cycles;
  int sent;
  glyph_checker board = new();

  fcmap_req_if req_ch();
  fcmap_rsp_if rsp_ch();

  font_cmap_glyph_lookup_unit dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req(req_ch), .rsp(rsp_ch)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    rst <= 1;
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    paddr <= 0;
    pwdata <= 0;
    req_ch.valid <= 0;
    req_ch.func <= FUNC_WRITE;
    req_ch.word_address <= 0;
    req_ch.word_data <= 0;
    req_ch.char_code <= 0;
    rsp_ch.ready <= 0;
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("font_cmap_glyph_lookup_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        rsp_ch.ready <= 0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1;
      do @(posedge clk); while (!rsp_ch.valid);
      board.check_glyph(rsp_ch.glyph_id, rsp_ch.table_fault);
    end
  end

  task automatic send(bit func, bit [12:0] addr, bit [15:0] data, bit [20:0] code, bit fast = 0);
    int gap;
    gap = (calm || fast) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      req_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1;
    req_ch.func <= func;
    req_ch.word_address <= addr;
    req_ch.word_data <= data;
    req_ch.char_code <= code;
    do @(posedge clk); while (!req_ch.ready);
    board.note_word(func, addr, data, code);
    if (!fast) sent++;
  endtask

  task automatic put_word(int unsigned addr, int unsigned data);
    send(FUNC_WRITE, addr[12:0], data[15:0], 21'($urandom()));
  endtask

  task automatic look(int unsigned code);
    send(FUNC_LOOKUP, 13'($urandom()), 16'($urandom()), code[20:0]);
  endtask

  task automatic drain();
    req_ch.valid <= 0;
    while (board.pending_glyphs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic apb_write(logic regsel, int unsigned value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {regsel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (regsel == REG_FORMAT) board.fmt = value[2:0];
    else board.segs = value[SEG_W-1:0];
  endtask

  task automatic configure(int unsigned fmt, int unsigned segs);
    drain();
    apb_write(REG_FORMAT, fmt);
    apb_write(REG_SEGCNT, segs);
    calm = ($urandom_range(0, 3) == 0);
  endtask

  // format 0: four glyph words, then byte lookups including codes past 255
  task automatic run_f0(int lookups);
    repeat (4) put_word(F0_BASE + $urandom_range(0, 127), $urandom());
    repeat (lookups) look($urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 300));
  endtask

  // format 2: subheaders for four high bytes, glyph array after them
  task automatic run_f2(int lookups);
    int unsigned hb [4];
    int unsigned sh, key, code;
    for (int k = 0; k < 4; k++) begin
      hb[k] = $urandom_range(0, 255);
      key = ($urandom_range(0, 7) == 0) ? 'hFFF8 : 8 * k;
      put_word(F2_KEY_BASE + hb[k], key);
      sh = F2_SUB_BASE + 4 * k;
      put_word(sh, $urandom_range(0, 255));
      put_word(sh + 1, $urandom_range(0, 256));
      put_word(sh + 2, $urandom());
      put_word(sh + 3, ($urandom_range(0, 7) == 0) ? $urandom() :
               2 * (300 - (sh + 3)) + $urandom_range(0, 1));
    end
    repeat (lookups) begin
      code = (hb[$urandom_range(0, 3)] << 8) | $urandom_range(0, 255);
      if ($urandom_range(0, 9) == 0) code = $urandom();
      look(code);
    end
  endtask

  // format 4: ascending end codes, starts at or below them (some above), mixed range offsets
  task automatic run_f4(int n, int lookups);
    int unsigned e, st, span, code, s;
    e = 0;
    for (int i = 0; i < n; i++) begin
      span = 65535 / n;
      e = (i == n - 1 && $urandom_range(0, 1)) ? 65535 : e + $urandom_range(1, span);
      if (e > 65535) e = 65535;
      put_word(F4_END_BASE + i, e);
      st = ($urandom_range(0, 7) == 0) ? e + 1 : e - $urandom_range(0, e < 40 ? e : 40);
      put_word(F4_START_BASE + n + i, st & 'hFFFF);
      put_word(F4_START_BASE + 2 * n + i, $urandom());
      case ($urandom_range(0, 5))
        0, 1: put_word(F4_START_BASE + 3 * n + i, 0);
        2: put_word(F4_START_BASE + 3 * n + i, $urandom());
        default: put_word(F4_START_BASE + 3 * n + i,
                          2 * (8 + 4 * n + 8 - i) + $urandom_range(0, 1));
      endcase
    end
    repeat (lookups) begin
      s = $urandom_range(0, n - 1);
      e = board.mem[F4_END_BASE + s];
      st = board.mem[F4_START_BASE + n + s];
      case ($urandom_range(0, 9))
        0: code = st - 1;
        1: code = e;
        2: code = e + 1;
        3: code = $urandom_range(0, 'h1FFFFF);
        default: code = st + $urandom_range(0, e > st ? e - st : 0);
      endcase
      look(code & 'h1FFFFF);
    end
  endtask

  initial begin
    int n;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int a = 0; a < TABLE_WORDS; a++)
      send(FUNC_WRITE, 13'(a), 16'($urandom()), 21'($urandom()), 1);
    look(0);
    look('h1FFFFF);
    look('hFFFF);
    run_f4(1, 2);
    configure(FMT_BYTE, 1);
    look(0);
    look(255);
    look(256);
    configure(FMT_HIGH_BYTE, 1);
    run_f2(4);
    configure(FMT_SEGMENT, 0);
    look(5);
    configure(FMT_SEGMENT, MAX_SEGMENTS);
    look(0);
    look($urandom_range(0, 65535));
    configure(FMT_SEGMENT, 4095);
    look($urandom_range(0, 65535));
    for (int f = 1; f < 8; f += 2) begin
      configure(f, $urandom_range(1, 4095));
      look($urandom());
    end
    while (sent < 600) begin
      case ($urandom_range(0, 2))
        0: begin
          configure(FMT_BYTE, $urandom_range(0, 4095));
          run_f0($urandom_range(10, 30));
        end
        1: begin
          configure(FMT_HIGH_BYTE, $urandom_range(0, 4095));
          run_f2($urandom_range(10, 30));
        end
        default: begin
          n = $urandom_range(1, 40);
          configure(FMT_SEGMENT, n);
          run_f4(n, $urandom_range(10, 30));
        end
      endcase
    end
    drain();
    $display("covered %0d words after table fill, %0d lookups over formats 0, 2, 4",
             sent, board.lookups);
    $display("and unsupported formats, with segment counts from 0 to 4095");
    if (board.errors == 0 && board.pending_glyphs.size() == 0)
      $display("font_cmap_glyph_lookup_unit regression: pass");
    else
      $display("font_cmap_glyph_lookup_unit regression: fail");
    $finish;
  end
endmodule
`default_nettype wire

// ===== font_cmap_glyph_lookup_unit.f =====
+incdir+rtl
rtl/fcmap_pkg.sv
rtl/fcmap_if.sv
rtl/fcmap_ram.sv
rtl/fcmap_seq.sv
rtl/font_cmap_glyph_lookup_unit.sv
bench/testbench.sv
